### rtl/teaching_cpu_execute_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the teaching CPU execute core checker.
// ----------------------------------------------------------------------------
`ifndef TEACHING_CPU_EXECUTE_CORE_MACROS_SVH
`define TEACHING_CPU_EXECUTE_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TCPU_CHK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define TCPU_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);

`endif

### rtl/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg
// Types, constants and opcodes shared by the teaching CPU execute core.
// ----------------------------------------------------------------------------
package tcpu_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int IO_DEPTH      = 256;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_BITS    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] IO_BASE     = 32'hFFFF_FF00;
    localparam logic [31:0] CONSOLE_OUT = 32'hFFFF_FF00;
    localparam logic [31:0] TERM_IN     = 32'hFFFF_FF04;
    localparam logic [31:0] PC_RESET    = 32'h4000_0000;

    localparam logic [3:0] ZERO_IDX = 4'd0;
    localparam logic [3:0] SP_IDX   = 4'd14;
    localparam logic [3:0] PC_IDX   = 4'd15;

    // Inspect addresses beyond the register file.
    localparam logic [31:0] INSP_PC     = 32'd15;
    localparam logic [31:0] INSP_STATUS = 32'd16;
    localparam logic [31:0] INSP_CAUSE  = 32'd18;
    localparam logic [31:0] INSP_IRQ    = 32'd19;

    localparam logic [1:0] CSR_STATUS  = 2'd0;
    localparam logic [1:0] CSR_HANDLER = 2'd1;
    localparam logic [1:0] CSR_CAUSE   = 2'd2;

    localparam logic [31:0] CAUSE_ILLEGAL = 32'd1;
    localparam logic [31:0] CAUSE_TIMER   = 32'd2;
    localparam logic [31:0] CAUSE_TERM    = 32'd3;
    localparam logic [31:0] CAUSE_SWI     = 32'd4;

    localparam logic [2:0] IRQ_TIMER = 3'b001;
    localparam logic [2:0] IRQ_TERM  = 3'b010;
    localparam logic [2:0] IRQ_SWI   = 3'b100;

    localparam logic [7:0] OPC_HALT   = 8'h00;
    localparam logic [7:0] OPC_SWI    = 8'h10;
    localparam logic [7:0] OPC_CALL   = 8'h20;
    localparam logic [7:0] OPC_CALLM  = 8'h21;
    localparam logic [7:0] OPC_JMP    = 8'h30;
    localparam logic [7:0] OPC_BEQ    = 8'h31;
    localparam logic [7:0] OPC_BNE    = 8'h32;
    localparam logic [7:0] OPC_BGT    = 8'h33;
    localparam logic [7:0] OPC_JMPM   = 8'h38;
    localparam logic [7:0] OPC_BEQM   = 8'h39;
    localparam logic [7:0] OPC_BNEM   = 8'h3A;
    localparam logic [7:0] OPC_BGTM   = 8'h3B;
    localparam logic [7:0] OPC_XCHG   = 8'h40;
    localparam logic [7:0] OPC_ADD    = 8'h50;
    localparam logic [7:0] OPC_SUB    = 8'h51;
    localparam logic [7:0] OPC_MUL    = 8'h52;
    localparam logic [7:0] OPC_DIV    = 8'h53;
    localparam logic [7:0] OPC_NOT    = 8'h60;
    localparam logic [7:0] OPC_AND    = 8'h61;
    localparam logic [7:0] OPC_OR     = 8'h62;
    localparam logic [7:0] OPC_XOR    = 8'h63;
    localparam logic [7:0] OPC_SHL    = 8'h70;
    localparam logic [7:0] OPC_SHR    = 8'h71;
    localparam logic [7:0] OPC_ST     = 8'h80;
    localparam logic [7:0] OPC_STPRE  = 8'h81;
    localparam logic [7:0] OPC_STIND  = 8'h82;
    localparam logic [7:0] OPC_CSRRD  = 8'h90;
    localparam logic [7:0] OPC_ADDI   = 8'h91;
    localparam logic [7:0] OPC_LD     = 8'h92;
    localparam logic [7:0] OPC_POP    = 8'h93;
    localparam logic [7:0] OPC_CSRWR  = 8'h94;
    localparam logic [7:0] OPC_CSRORI = 8'h95;
    localparam logic [7:0] OPC_CSRLD  = 8'h96;
    localparam logic [7:0] OPC_CSRPOP = 8'h97;

    typedef enum logic [2:0] {
        K_LOAD,
        K_EXEC,
        K_TERM,
        K_TICK,
        K_INSP,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [7:0]  dbyte;
    } t_item;

    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] addr;
        logic [7:0]  wdata;
    } t_mreq;

    typedef struct packed {
        logic        halted;
        logic        illegal_op;
        logic [31:0] prog_counter;
        logic        console_valid;
        logic [7:0]  console_char;
        logic [2:0]  took_cause;
        logic [31:0] read_value;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_MRD,
        S_MWR,
        S_DECODE,
        S_REGS,
        S_EXEC,
        S_LOADED,
        S_CALLED,
        S_DIVW,
        S_WR2,
        S_CON,
        S_CON2,
        S_IRQ1,
        S_IRQ2,
        S_IRQ3,
        S_INSP,
        S_DONE
    } t_state;

endpackage

### rtl/tcpu_front.sv
// ----------------------------------------------------------------------------
// tcpu_front
// Accepts input words, classifies the operation and queues them for the back.
// ----------------------------------------------------------------------------
module tcpu_front
    import tcpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_addr,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item                 r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wp;
    logic [Q_PTR_BITS-1:0] r_rp;
    logic [Q_CNT_BITS-1:0] r_count;
    logic                  push;
    t_item                 item;

    function automatic t_kind classify(logic [2:0] op);
        t_kind k;
        case (op)
            3'd0:    k = K_LOAD;
            3'd1:    k = K_EXEC;
            3'd2:    k = K_TERM;
            3'd3:    k = K_TICK;
            3'd4:    k = K_INSP;
            default: k = K_NOP;
        endcase
        return k;
    endfunction

    assign o_stall = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        item.kind  = classify(i_op);
        item.addr  = i_addr;
        item.dbyte = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + Q_CNT_BITS'(push) - Q_CNT_BITS'(i_pop);
        end
    end

endmodule

### rtl/tcpu_mem.sv
// ----------------------------------------------------------------------------
// tcpu_mem
// Byte memory: main memory plus the I/O page, one access a cycle, registered
// read data, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module tcpu_mem
    import tcpu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mreq      i_req,
    output logic [7:0] o_rdata,
    output logic       o_busy
);

    logic [7:0]             main_mem [MEM_DEPTH];
    logic [7:0]             io_mem   [IO_DEPTH];
    logic [MEM_ADDR_BITS:0] r_clr;
    logic [7:0]             r_main_q;
    logic [7:0]             r_io_q;
    logic                   r_io_sel;
    logic                   io_hit;

    assign io_hit  = ((i_req.addr & IO_BASE) == IO_BASE);
    assign o_busy  = !r_clr[MEM_ADDR_BITS];
    assign o_rdata = r_io_sel ? r_io_q : r_main_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (o_busy) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // The I/O page is swept along with the bottom of main memory.
    always_ff @(posedge i_clk) begin
        if (o_busy) begin
            main_mem[r_clr[MEM_ADDR_BITS-1:0]] <= '0;
        end else if (i_req.wr && !io_hit) begin
            main_mem[i_req.addr[MEM_ADDR_BITS-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_busy) begin
            io_mem[r_clr[7:0]] <= '0;
        end else if (i_req.wr && io_hit) begin
            io_mem[i_req.addr[7:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_main_q <= main_mem[i_req.addr[MEM_ADDR_BITS-1:0]];
            r_io_q   <= io_mem[i_req.addr[7:0]];
            r_io_sel <= io_hit;
        end
    end

endmodule

### rtl/tcpu_div.sv
// ----------------------------------------------------------------------------
// tcpu_div
// Signed truncating divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tcpu_div
    import tcpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_done,
    output logic [31:0] o_q
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_my;
    logic        r_neg;
    logic        r_zero;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_q[31]};
    assign diff   = rem_sh - {1'b0, r_my};
    assign ge     = !diff[32];
    assign o_done = r_done;
    assign o_q    = r_zero ? '1 : (r_neg ? 32'd0 - r_q : r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_y == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 5'd31;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_y == '0);
            r_neg  <= i_x[31] ^ i_y[31];
            r_my   <= i_y[31] ? 32'd0 - i_y : i_y;
            r_q    <= i_x[31] ? 32'd0 - i_x : i_x;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
            r_q   <= {r_q[30:0], ge};
        end
    end

endmodule

### rtl/tcpu_back.sv
// ----------------------------------------------------------------------------
// tcpu_back
// Sequencer that carries out queued words: instruction fetch and decode,
// register file, CSRs, interrupt entry and the result register.
// ----------------------------------------------------------------------------
module tcpu_back
    import tcpu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output t_mreq   o_mreq,
    input  logic [7:0] i_rdata,
    input  logic    i_mem_busy,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_res
);

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [2:0]  r_cnt, n_cnt;
    t_item       r_item, n_item;
    logic [31:0] r_ins, n_ins;
    logic [31:0] r_ra, n_ra;
    logic [31:0] r_rb, n_rb;
    logic [31:0] r_rc, n_rc;
    logic [31:0] r_rsp, n_rsp;
    logic [31:0] r_tmp, n_tmp;
    logic [31:0] r_maddr, n_maddr;
    logic [31:0] r_wdata, n_wdata;
    logic [31:0] r_word, n_word;
    logic [3:0]  r_w2idx, n_w2idx;
    logic [31:0] r_w2val, n_w2val;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_status, n_status;
    logic [31:0] r_handler, n_handler;
    logic [31:0] r_cause, n_cause;
    logic [2:0]  r_pend, n_pend;
    logic        r_stopped, n_stopped;
    logic        r_ill, n_ill;
    logic        r_cval, n_cval;
    logic [7:0]  r_cchar, n_cchar;
    logic [2:0]  r_took, n_took;
    logic [31:0] r_rv, n_rv;
    logic        r_out_valid;
    t_result     r_out;
    logic        out_load;

    logic [31:0] gpr [16];
    logic [15:0] r_gvld;
    logic [31:0] r_grd;
    logic [3:0]  r_gidx;
    logic [3:0]  g_ridx;
    logic        g_we;
    logic [3:0]  g_widx;
    logic [31:0] g_wval;
    logic [31:0] gv;

    logic        csr_we;
    logic [1:0]  csr_widx;
    logic [31:0] csr_wval;

    logic        div_start;
    logic        div_done;
    logic [31:0] div_q;

    logic [7:0]  code;
    logic [3:0]  fa, fb, fc;
    logic [31:0] disp;
    logic [31:0] sp_m4;
    logic [31:0] ra_c, rb_c;
    logic        cond_ok;
    logic [2:0]  irq_t;
    logic [31:0] csr_b;

    function automatic logic [31:0] csr_get(logic [3:0] idx, logic [31:0] st,
                                            logic [31:0] hd, logic [31:0] cs);
        logic [31:0] v;
        case (idx)
            4'd0:    v = st;
            4'd1:    v = hd;
            4'd2:    v = cs;
            default: v = '0;
        endcase
        return v;
    endfunction

    tcpu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (r_rb),
        .i_y     (r_rc),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // Decode of the latched instruction.
    always_comb begin
        code  = r_ins[31:24];
        fa    = r_ins[23:20];
        fb    = r_ins[19:16];
        fc    = r_ins[15:12];
        disp  = {{20{r_ins[11]}}, r_ins[11:0]};
        sp_m4 = r_rsp - 32'd4;
        // A call pushes first, so its target sees the lowered stack pointer.
        ra_c  = (fa == SP_IDX) ? sp_m4 : r_ra;
        rb_c  = (fb == SP_IDX) ? sp_m4 : r_rb;
        case (code[1:0])
            2'd1:    cond_ok = (r_rb == r_rc);
            2'd2:    cond_ok = (r_rb != r_rc);
            2'd3:    cond_ok = ($signed(r_rb) > $signed(r_rc));
            default: cond_ok = 1'b1;
        endcase
        irq_t = r_pend & ~r_status[2:0];
        csr_b = csr_get(fb, r_status, r_handler, r_cause);
        gv    = (r_gidx == PC_IDX) ? r_pc : (r_gvld[r_gidx] ? r_grd : '0);
    end

    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !i_mem_busy) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                n_cnt   = '0;
                case (r_item.kind)
                    K_EXEC: begin
                        if (!r_stopped) begin
                            n_state = S_MRD;
                            n_ret   = S_DECODE;
                        end
                    end
                    K_TERM: begin
                        if (!r_stopped) begin
                            n_state = S_MWR;
                            n_ret   = S_DONE;
                        end
                    end
                    K_INSP: begin
                        if (r_item.addr < INSP_PC) begin
                            n_state = S_INSP;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MRD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd4) begin
                    n_state = r_ret;
                    n_cnt   = '0;
                end
            end
            S_MWR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd3) begin
                    n_state = r_ret;
                    n_cnt   = '0;
                end
            end
            S_DECODE: begin
                n_state = S_REGS;
                n_cnt   = '0;
            end
            S_REGS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd4) begin
                    n_state = S_EXEC;
                    n_cnt   = '0;
                end
            end
            S_EXEC: begin
                n_cnt = '0;
                case (code)
                    OPC_HALT: n_state = S_DONE;
                    OPC_CALL, OPC_CALLM: begin
                        n_state = S_MWR;
                        n_ret   = S_CALLED;
                    end
                    OPC_JMPM, OPC_BEQM, OPC_BNEM, OPC_BGTM: begin
                        if (cond_ok) begin
                            n_state = S_MRD;
                            n_ret   = S_LOADED;
                        end else begin
                            n_state = S_CON;
                        end
                    end
                    OPC_XCHG: n_state = S_WR2;
                    OPC_DIV:  n_state = S_DIVW;
                    OPC_ST, OPC_STPRE: begin
                        n_state = S_MWR;
                        n_ret   = S_CON;
                    end
                    OPC_STIND, OPC_LD, OPC_POP, OPC_CSRLD, OPC_CSRPOP: begin
                        n_state = S_MRD;
                        n_ret   = S_LOADED;
                    end
                    OPC_SWI, OPC_JMP, OPC_BEQ, OPC_BNE, OPC_BGT, OPC_ADD, OPC_SUB,
                    OPC_MUL, OPC_NOT, OPC_AND, OPC_OR, OPC_XOR, OPC_SHL, OPC_SHR,
                    OPC_CSRRD, OPC_ADDI, OPC_CSRWR, OPC_CSRORI: n_state = S_CON;
                    default: n_state = S_DONE;
                endcase
            end
            S_LOADED: begin
                n_cnt = '0;
                case (code)
                    OPC_STIND: begin
                        n_state = S_MWR;
                        n_ret   = S_CON;
                    end
                    OPC_POP: n_state = S_WR2;
                    default: n_state = S_CON;
                endcase
            end
            S_CALLED: begin
                n_cnt = '0;
                if (code == OPC_CALL) begin
                    n_state = S_CON;
                end else begin
                    n_state = S_MRD;
                    n_ret   = S_LOADED;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_CON;
                end
            end
            S_WR2:  n_state = S_CON;
            S_CON:  n_state = S_CON2;
            S_CON2: n_state = (irq_t != '0) ? S_IRQ1 : S_DONE;
            S_IRQ1: begin
                n_state = S_MWR;
                n_ret   = S_IRQ2;
                n_cnt   = '0;
            end
            S_IRQ2: begin
                n_state = S_MWR;
                n_ret   = S_IRQ3;
                n_cnt   = '0;
            end
            S_IRQ3: n_state = S_DONE;
            S_INSP: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_item    = r_item;
        n_ins     = r_ins;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_rc      = r_rc;
        n_rsp     = r_rsp;
        n_tmp     = r_tmp;
        n_maddr   = r_maddr;
        n_wdata   = r_wdata;
        n_word    = r_word;
        n_w2idx   = r_w2idx;
        n_w2val   = r_w2val;
        n_pc      = r_pc;
        n_status  = r_status;
        n_handler = r_handler;
        n_cause   = r_cause;
        n_pend    = r_pend;
        n_stopped = r_stopped;
        n_ill     = r_ill;
        n_cval    = r_cval;
        n_cchar   = r_cchar;
        n_took    = r_took;
        n_rv      = r_rv;
        o_pop     = 1'b0;
        o_mreq    = '0;
        g_ridx    = ZERO_IDX;
        g_we      = 1'b0;
        g_widx    = ZERO_IDX;
        g_wval    = '0;
        csr_we    = 1'b0;
        csr_widx  = CSR_STATUS;
        csr_wval  = '0;
        div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && !i_mem_busy) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_ill   = 1'b0;
                    n_cval  = 1'b0;
                    n_cchar = '0;
                    n_took  = '0;
                    n_rv    = '0;
                end
            end
            S_DISP: begin
                case (r_item.kind)
                    K_LOAD: begin
                        o_mreq.wr    = 1'b1;
                        o_mreq.addr  = r_item.addr;
                        o_mreq.wdata = r_item.dbyte;
                    end
                    K_EXEC: n_maddr = r_pc;
                    K_TERM: begin
                        n_maddr = TERM_IN;
                        n_wdata = {24'd0, r_item.dbyte};
                        if (!r_stopped) begin
                            n_pend = r_pend | IRQ_TERM;
                        end
                    end
                    K_TICK: begin
                        if (!r_stopped) begin
                            n_pend = r_pend | IRQ_TIMER;
                        end
                    end
                    K_INSP: begin
                        g_ridx = r_item.addr[3:0];
                        if (r_item.addr == INSP_PC) begin
                            n_rv = r_pc;
                        end else if (r_item.addr >= INSP_STATUS
                                     && r_item.addr <= INSP_CAUSE) begin
                            n_rv = csr_get({2'b00, r_item.addr[1:0]}, r_status,
                                           r_handler, r_cause);
                        end else if (r_item.addr == INSP_IRQ) begin
                            n_rv = {29'd0, r_pend};
                        end
                    end
                    default: n_rv = r_rv;
                endcase
            end
            S_MRD: begin
                if (r_cnt != 3'd4) begin
                    o_mreq.rd   = 1'b1;
                    o_mreq.addr = r_maddr;
                    n_maddr     = r_maddr + 32'd1;
                end
                // Bytes arrive lowest first and shift in from the top.
                if (r_cnt != 3'd0) begin
                    n_word = {i_rdata, r_word[31:8]};
                end
            end
            S_MWR: begin
                o_mreq.wr    = 1'b1;
                o_mreq.addr  = r_maddr;
                o_mreq.wdata = r_wdata[7:0];
                n_maddr      = r_maddr + 32'd1;
                n_wdata      = {8'd0, r_wdata[31:8]};
            end
            S_DECODE: begin
                n_ins = r_word;
                n_pc  = r_pc + 32'd4;
            end
            S_REGS: begin
                case (r_cnt)
                    3'd0:    g_ridx = r_ins[23:20];
                    3'd1:    g_ridx = r_ins[19:16];
                    3'd2:    g_ridx = r_ins[15:12];
                    3'd3:    g_ridx = SP_IDX;
                    default: g_ridx = ZERO_IDX;
                endcase
                case (r_cnt)
                    3'd1:    n_ra  = gv;
                    3'd2:    n_rb  = gv;
                    3'd3:    n_rc  = gv;
                    3'd4:    n_rsp = gv;
                    default: n_ra  = r_ra;
                endcase
            end
            S_EXEC: begin
                case (code)
                    OPC_HALT: n_stopped = 1'b1;
                    OPC_SWI:  n_pend = IRQ_SWI;
                    OPC_CALL, OPC_CALLM: begin
                        g_we    = 1'b1;
                        g_widx  = SP_IDX;
                        g_wval  = sp_m4;
                        n_maddr = sp_m4;
                        n_wdata = r_pc;
                        n_tmp   = ra_c + rb_c + disp;
                    end
                    OPC_JMP, OPC_BEQ, OPC_BNE, OPC_BGT: begin
                        if (cond_ok) begin
                            n_pc = r_ra + disp;
                        end
                    end
                    OPC_JMPM, OPC_BEQM, OPC_BNEM, OPC_BGTM: n_maddr = r_ra + disp;
                    OPC_XCHG: begin
                        g_we    = 1'b1;
                        g_widx  = fb;
                        g_wval  = r_rc;
                        n_w2idx = fc;
                        n_w2val = r_rb;
                    end
                    OPC_ADD, OPC_SUB, OPC_MUL, OPC_NOT, OPC_AND, OPC_OR, OPC_XOR,
                    OPC_SHL, OPC_SHR, OPC_CSRRD, OPC_ADDI: begin
                        g_we   = 1'b1;
                        g_widx = fa;
                        case (code)
                            OPC_ADD: g_wval = r_rb + r_rc;
                            OPC_SUB: g_wval = r_rb - r_rc;
                            OPC_MUL: g_wval = r_rb * r_rc;
                            OPC_NOT: g_wval = ~r_rb;
                            OPC_AND: g_wval = r_rb & r_rc;
                            OPC_OR:  g_wval = r_rb | r_rc;
                            OPC_XOR: g_wval = r_rb ^ r_rc;
                            OPC_SHL: g_wval = (r_rc >= 32'd32) ? '0 : r_rb << r_rc[4:0];
                            OPC_SHR: g_wval = (r_rc >= 32'd32) ? {32{r_rb[31]}}
                                             : 32'($signed(r_rb) >>> r_rc[4:0]);
                            OPC_CSRRD: g_wval = csr_b;
                            default: g_wval = r_rb + disp;
                        endcase
                    end
                    OPC_DIV: div_start = 1'b1;
                    OPC_ST: begin
                        n_maddr = r_ra + r_rb + disp;
                        n_wdata = r_rc;
                    end
                    OPC_STPRE: begin
                        g_we    = 1'b1;
                        g_widx  = fa;
                        g_wval  = r_ra + disp;
                        n_maddr = r_ra + disp;
                        // The stored register is read after the base update.
                        n_wdata = (fc == fa) ? r_ra + disp : r_rc;
                    end
                    OPC_STIND: n_maddr = r_ra + r_rb + disp;
                    OPC_LD, OPC_CSRLD: n_maddr = r_rb + r_rc + disp;
                    OPC_POP, OPC_CSRPOP: n_maddr = r_rb;
                    OPC_CSRWR: begin
                        csr_we   = 1'b1;
                        csr_widx = fa[1:0];
                        csr_wval = r_rb;
                    end
                    OPC_CSRORI: begin
                        csr_we   = 1'b1;
                        csr_widx = fa[1:0];
                        csr_wval = csr_b | disp;
                    end
                    default: begin
                        n_cause   = CAUSE_ILLEGAL;
                        n_stopped = 1'b1;
                        n_ill     = 1'b1;
                    end
                endcase
                // CSR numbers above two are not writable.
                if (fa[3:2] != 2'b00 || fa[1:0] == 2'b11) begin
                    csr_we = 1'b0;
                end
            end
            S_LOADED: begin
                case (code)
                    OPC_STIND: begin
                        n_maddr = r_word;
                        n_wdata = r_rc;
                    end
                    OPC_LD: begin
                        g_we   = 1'b1;
                        g_widx = fa;
                        g_wval = r_word;
                    end
                    OPC_POP: begin
                        g_we    = 1'b1;
                        g_widx  = fa;
                        g_wval  = r_word;
                        n_w2idx = fb;
                        n_w2val = ((fa == fb) ? r_word : r_rb) + disp;
                    end
                    OPC_CSRLD, OPC_CSRPOP: begin
                        csr_we   = !(fa[3:2] != 2'b00 || fa[1:0] == 2'b11);
                        csr_widx = fa[1:0];
                        csr_wval = r_word;
                        if (code == OPC_CSRPOP) begin
                            g_we   = 1'b1;
                            g_widx = fb;
                            g_wval = r_rb + disp;
                        end
                    end
                    default: n_pc = r_word;
                endcase
            end
            S_CALLED: begin
                if (code == OPC_CALL) begin
                    n_pc = r_tmp;
                end else begin
                    n_maddr = r_tmp;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    g_we   = 1'b1;
                    g_widx = fa;
                    g_wval = div_q;
                end
            end
            S_WR2: begin
                g_we   = 1'b1;
                g_widx = r_w2idx;
                g_wval = r_w2val;
            end
            S_CON: begin
                o_mreq.rd   = 1'b1;
                o_mreq.addr = CONSOLE_OUT;
            end
            S_CON2: begin
                g_ridx = SP_IDX;
                if (i_rdata != '0) begin
                    n_cval       = 1'b1;
                    n_cchar      = i_rdata;
                    o_mreq.wr    = 1'b1;
                    o_mreq.addr  = CONSOLE_OUT;
                    o_mreq.wdata = '0;
                end
            end
            S_IRQ1: begin
                n_rsp   = gv;
                n_maddr = gv - 32'd4;
                n_wdata = r_status;
                g_we    = 1'b1;
                g_widx  = SP_IDX;
                g_wval  = gv - 32'd8;
            end
            S_IRQ2: begin
                n_maddr = r_rsp - 32'd8;
                n_wdata = r_pc;
            end
            S_IRQ3: begin
                if (irq_t[2]) begin
                    n_cause  = CAUSE_SWI;
                    n_status = r_status | 32'h7;
                    n_pend   = r_pend & 3'h3;
                end else if (irq_t[1]) begin
                    n_cause  = CAUSE_TERM;
                    n_status = r_status | 32'h3;
                    n_pend   = r_pend & 3'h5;
                end else begin
                    n_cause  = CAUSE_TIMER;
                    n_status = r_status | 32'h1;
                    n_pend   = r_pend & 3'h6;
                end
                n_took = n_cause[2:0];
                n_pc   = r_handler;
            end
            S_INSP: n_rv = gv;
            default: n_rv = r_rv;
        endcase

        if (csr_we) begin
            case (csr_widx)
                CSR_STATUS:  n_status  = csr_wval;
                CSR_HANDLER: n_handler = csr_wval;
                CSR_CAUSE:   n_cause   = csr_wval;
                default:     n_cause   = r_cause;
            endcase
        end
        if (g_we && g_widx == PC_IDX) begin
            n_pc = g_wval;
        end
    end

    // Register file: r0 writes are dropped, r15 lives in the pc register.
    always_ff @(posedge i_clk) begin
        if (g_we && g_widx != ZERO_IDX && g_widx != PC_IDX) begin
            gpr[g_widx] <= g_wval;
        end
        r_grd  <= gpr[g_ridx];
        r_gidx <= g_ridx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_pc        <= PC_RESET;
            r_status    <= '0;
            r_handler   <= '0;
            r_cause     <= '0;
            r_pend      <= '0;
            r_stopped   <= 1'b0;
            r_gvld      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_cnt     <= n_cnt;
            r_pc      <= n_pc;
            r_status  <= n_status;
            r_handler <= n_handler;
            r_cause   <= n_cause;
            r_pend    <= n_pend;
            r_stopped <= n_stopped;
            if (g_we && g_widx != ZERO_IDX && g_widx != PC_IDX) begin
                r_gvld[g_widx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_ins   <= n_ins;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_rc    <= n_rc;
        r_rsp   <= n_rsp;
        r_tmp   <= n_tmp;
        r_maddr <= n_maddr;
        r_wdata <= n_wdata;
        r_word  <= n_word;
        r_w2idx <= n_w2idx;
        r_w2val <= n_w2val;
        r_ill   <= n_ill;
        r_cval  <= n_cval;
        r_cchar <= n_cchar;
        r_took  <= n_took;
        r_rv    <= n_rv;
        if (out_load) begin
            r_out.halted        <= r_stopped;
            r_out.illegal_op    <= r_ill;
            r_out.prog_counter  <= r_pc;
            r_out.console_valid <= r_cval;
            r_out.console_char  <= r_cchar;
            r_out.took_cause    <= r_took;
            r_out.read_value    <= r_rv;
        end
    end

endmodule

### rtl/teaching_cpu_execute_core.sv
// ----------------------------------------------------------------------------
// teaching_cpu_execute_core
// Execute core of a 32-bit, 16-register teaching CPU with byte memory,
// CSRs and three interrupt sources.
//
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_stall    i_op, i_addr, i_data_byte
//   output    o_out_valid / i_out_stall  o_halted .. o_read_value
//
// Words pass through a two-entry queue to a sequencer that does one at a time.
// In the sequencer an instruction reads and writes words through the byte-wide
// memory port a byte at a time, and a divide waits for the divider to finish.
// After reset a clearing pass sweeps the memory before the first word starts;
// words still queue during it.
// A stalled result holds in the output register while the next word works.
// ----------------------------------------------------------------------------
module teaching_cpu_execute_core
    import tcpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_addr,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_halted,
    output logic        o_illegal_op,
    output logic [31:0] o_prog_counter,
    output logic        o_console_valid,
    output logic [7:0]  o_console_char,
    output logic [2:0]  o_took_cause,
    output logic [31:0] o_read_value
);

    logic       q_valid;
    t_item      q_item;
    logic       q_pop;
    t_mreq      mreq;
    logic [7:0] mem_rdata;
    logic       mem_busy;
    t_result    res;

    tcpu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_op        (i_op),
        .i_addr      (i_addr),
        .i_data_byte (i_data_byte),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_pop       (q_pop)
    );

    tcpu_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    tcpu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_mreq      (mreq),
        .i_rdata     (mem_rdata),
        .i_mem_busy  (mem_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_halted        = res.halted;
    assign o_illegal_op    = res.illegal_op;
    assign o_prog_counter  = res.prog_counter;
    assign o_console_valid = res.console_valid;
    assign o_console_char  = res.console_char;
    assign o_took_cause    = res.took_cause;
    assign o_read_value    = res.read_value;

endmodule

### rtl/tcpu_checker.sv
// ----------------------------------------------------------------------------
// tcpu_checker
// Port-level checks on the execute core's input and result channels.
// ----------------------------------------------------------------------------
`include "teaching_cpu_execute_core_macros.svh"

module tcpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_op,
    input logic [31:0] i_addr,
    input logic [7:0]  i_data_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_halted,
    input logic        o_illegal_op,
    input logic [31:0] o_prog_counter,
    input logic        o_console_valid,
    input logic [7:0]  o_console_char,
    input logic [2:0]  o_took_cause,
    input logic [31:0] o_read_value
);

    `TCPU_CHK_NEXT(a_in_hold, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_op) && $stable(i_addr) && $stable(i_data_byte),
        "stalled input word changed")
    `TCPU_CHK_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_prog_counter) && $stable(o_read_value),
        "stalled result word changed")
    `TCPU_CHK(a_ill_halts, o_out_valid && o_illegal_op |-> o_halted,
        "illegal opcode without halt")
    `TCPU_CHK(a_irq_running, o_out_valid && o_took_cause != 3'd0 |->
        !o_halted && !o_illegal_op, "interrupt entered on a stopped core")
    `TCPU_CHK(a_con_quiet, o_out_valid && !o_console_valid |-> o_console_char == 8'd0,
        "console byte without console valid")

endmodule

bind teaching_cpu_execute_core tcpu_checker u_tcpu_checker (.*);
